// ===== design/pce_pkg.sv =====
`timescale 1ns / 1ps

package pce_pkg;

	localparam int MAX_DEVICES = 64;

	typedef enum logic [2:0] {
		KIND_REQUEST = 3'd0,
		KIND_IDENTITY = 3'd1,
		KIND_BAR = 3'd2,
		KIND_DEV_END = 3'd3,
		KIND_FINISH = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_ID = 3'd0,
		PH_CLASS = 3'd1,
		PH_BAR = 3'd2,
		PH_BARHI = 3'd3,
		PH_IRQ = 3'd4,
		PH_HDR = 3'd5
	} phase_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_BASE = 2'd1;
	localparam logic [1:0] ST_NONE_FOUND = 2'd2;

	localparam logic [1:0] REG_ECAM_BASE = 2'd0;
	localparam logic [1:0] REG_FIRST_BUS = 2'd1;
	localparam logic [1:0] REG_LAST_BUS = 2'd2;

	localparam logic OP_START = 1'b0;

	typedef struct packed {
		logic busy;
		phase_t phase;
		logic [7:0] bus;
		logic [4:0] dev;
		logic [2:0] fn;
		logic [2:0] bar_slot;
		logic [6:0] count;
		logic [31:0] held_identity;
		logic [31:0] held_bar_low;
	} scan_state_t;

	typedef struct packed {
		kind_t kind;
		logic [63:0] address;
		logic [7:0] bus_number;
		logic [4:0] device_number;
		logic [2:0] function_number;
		logic [31:0] identity;
		logic [23:0] class_triple;
		logic [2:0] bar_index;
		logic [63:0] value;
		logic [1:0] status;
		logic last;
	} result_t;

endpackage

// ===== design/pce_step.sv =====
`timescale 1ns / 1ps

module pce_step (
	input pce_pkg::scan_state_t st,
	input logic op,
	input logic [31:0] data,
	input logic [63:0] ecam_base,
	input logic [7:0] first_bus,
	input logic [7:0] last_bus,
	output pce_pkg::scan_state_t st_next,
	output pce_pkg::result_t res [3],
	output logic [1:0] n
);

	localparam logic [11:0] OFF_ID = 12'h000;
	localparam logic [11:0] OFF_CLASS = 12'h008;
	localparam logic [11:0] OFF_HDR = 12'h00c;
	localparam logic [11:0] OFF_BAR0 = 12'h010;
	localparam logic [11:0] OFF_IRQ = 12'h03c;

	typedef struct packed {
		logic fin;
		logic [1:0] status;
		logic [7:0] bus;
		logic [4:0] dev;
		logic [2:0] fn;
	} walk_t;

	logic [7:0] end_bus;
	logic limit;
	logic [1:0] done_status;
	walk_t nd, nf, here;

	function automatic pce_pkg::result_t at_here(input pce_pkg::scan_state_t s,
			input pce_pkg::kind_t k);
		pce_pkg::result_t r;
		r = '0;
		r.kind = k;
		r.bus_number = s.bus;
		r.device_number = s.dev;
		r.function_number = s.fn;
		return r;
	endfunction

	// walk to the next slot / next function, as seen from the current position
	always_comb begin
		end_bus = (last_bus < first_bus) ? first_bus : last_bus;
		limit = st.count >= 7'(pce_pkg::MAX_DEVICES);
		done_status = (st.count != 7'd0) ? pce_pkg::ST_OK : pce_pkg::ST_NONE_FOUND;
		here = '{fin: 1'b0, status: done_status, bus: st.bus, dev: st.dev, fn: st.fn};
		nd = '{fin: 1'b1, status: done_status, bus: st.bus, dev: st.dev, fn: 3'd0};
		if (!limit) begin
			if (st.dev != 5'd31) begin
				nd.fin = 1'b0;
				nd.dev = st.dev + 5'd1;
			end else if (!(st.bus == 8'hff || st.bus >= end_bus)) begin
				nd.fin = 1'b0;
				nd.bus = st.bus + 8'd1;
				nd.dev = 5'd0;
			end
		end
		nf = nd;
		if (!limit && st.fn != 3'd7) begin
			nf = here;
			nf.fn = st.fn + 3'd1;
		end
	end

	pce_pkg::result_t pre0, pre1, tail;
	logic [1:0] k;
	logic use_tail;
	walk_t w;
	logic [11:0] off;
	logic [2:0] s;

	always_comb begin
		st_next = st;
		pre0 = '0;
		pre1 = '0;
		k = 2'd0;
		use_tail = 1'b1;
		w = here;
		off = OFF_ID;
		s = st.bar_slot;

		if (op == pce_pkg::OP_START) begin
			if (ecam_base == 64'd0) begin
				w.fin = 1'b1;
				w.status = pce_pkg::ST_NO_BASE;
			end else begin
				st_next.count = 7'd0;
				st_next.bar_slot = 3'd0;
				st_next.phase = pce_pkg::PH_ID;
				st_next.busy = 1'b1;
				w = '{fin: 1'b0, status: pce_pkg::ST_OK, bus: first_bus, dev: 5'd0,
					fn: 3'd0};
			end
		end else if (!st.busy) begin
			use_tail = 1'b0;
		end else begin
			case (st.phase)
				pce_pkg::PH_ID: begin
					if (data[15:0] == 16'hffff) begin
						w = (st.fn == 3'd0) ? nd : nf;
						st_next.phase = pce_pkg::PH_ID;
					end else begin
						st_next.held_identity = data;
						st_next.phase = pce_pkg::PH_CLASS;
						off = OFF_CLASS;
					end
				end
				pce_pkg::PH_CLASS: begin
					st_next.count = st.count + 7'd1;
					pre0 = at_here(st, pce_pkg::KIND_IDENTITY);
					pre0.identity = st.held_identity;
					pre0.class_triple = data[31:8];
					k = 2'd1;
					s = 3'd0;
				end
				pce_pkg::PH_BAR: begin
					pre0 = at_here(st, pce_pkg::KIND_BAR);
					pre0.bar_index = st.bar_slot;
					k = 2'd1;
					s = st.bar_slot + 3'd1;
					if (data == 32'd0 || data == 32'hffffffff) begin
						pre0.value = 64'd0;
					end else if (data[0]) begin
						pre0.value = {32'd0, data[31:2], 2'b00};
					end else if (data[2:1] == 2'd2 && st.bar_slot < 3'd5) begin
						// 64-bit memory BAR: fetch the upper half first
						k = 2'd0;
						st_next.held_bar_low = data;
						st_next.phase = pce_pkg::PH_BARHI;
						s = st.bar_slot;
					end else begin
						pre0.value = {32'd0, data[31:4], 4'b0000};
					end
				end
				pce_pkg::PH_BARHI: begin
					pre0 = at_here(st, pce_pkg::KIND_BAR);
					pre0.bar_index = st.bar_slot;
					pre0.value = {data, st.held_bar_low[31:4], 4'b0000};
					pre1 = at_here(st, pce_pkg::KIND_BAR);
					pre1.bar_index = st.bar_slot + 3'd1;
					k = 2'd2;
					s = st.bar_slot + 3'd2;
				end
				pce_pkg::PH_IRQ: begin
					pre0 = at_here(st, pce_pkg::KIND_DEV_END);
					pre0.value = {56'd0, data[7:0]};
					k = 2'd1;
					if (st.fn == 3'd0) begin
						st_next.phase = pce_pkg::PH_HDR;
						off = OFF_HDR;
					end else begin
						w = nf;
						st_next.phase = pce_pkg::PH_ID;
					end
				end
				default: begin
					w = data[23] ? nf : nd;
					st_next.phase = pce_pkg::PH_ID;
				end
			endcase

			// slot walk after the identity record or a BAR has been reported
			if (st.phase == pce_pkg::PH_CLASS || st.phase == pce_pkg::PH_BARHI ||
					(st.phase == pce_pkg::PH_BAR && k != 2'd0)) begin
				st_next.bar_slot = s;
				if (s < 3'd6) begin
					st_next.phase = pce_pkg::PH_BAR;
					off = OFF_BAR0 + {7'd0, s, 2'b00};
				end else begin
					st_next.phase = pce_pkg::PH_IRQ;
					off = OFF_IRQ;
				end
			end else if (st.phase == pce_pkg::PH_BAR) begin
				off = OFF_BAR0 + {7'd0, st.bar_slot + 3'd1, 2'b00};
			end
		end

		tail = '0;
		tail.last = 1'b1;
		if (w.fin) begin
			tail.kind = pce_pkg::KIND_FINISH;
			tail.value = {57'd0, st_next.count};
			tail.status = w.status;
			st_next.busy = 1'b0;
		end else begin
			tail.kind = pce_pkg::KIND_REQUEST;
			tail.address = ecam_base + {36'd0, w.bus, w.dev, w.fn, off};
			tail.bus_number = w.bus;
			tail.device_number = w.dev;
			tail.function_number = w.fn;
			if (use_tail) begin
				st_next.bus = w.bus;
				st_next.dev = w.dev;
				st_next.fn = w.fn;
			end
		end

		res[0] = pre0;
		res[1] = pre1;
		res[2] = '0;
		res[k] = tail;
		n = use_tail ? k + 2'd1 : 2'd0;
		if (!use_tail) begin
			st_next = st;
		end
	end

endmodule

// ===== design/pce_rbuf.sv =====
`timescale 1ns / 1ps

module pce_rbuf (
	input logic clk,
	input logic arst_n,
	input logic load,
	input pce_pkg::result_t res [3],
	input logic [1:0] n,
	input logic ready,
	output logic valid,
	output pce_pkg::result_t head,
	output logic can_load
);

	pce_pkg::result_t slot_q [3];
	logic [1:0] n_q;
	logic pop;

	assign valid = n_q != 2'd0;
	assign head = slot_q[0];
	assign pop = valid && ready;
	// refill only once the buffer is empty or its last queued result leaves this cycle
	assign can_load = (n_q == 2'd0) || (n_q == 2'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 2'd0;
		end else if (load) begin
			n_q <= n;
		end else if (pop) begin
			n_q <= n_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q[0] <= res[0];
			slot_q[1] <= res[1];
			slot_q[2] <= res[2];
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

// ===== design/pci_config_space_enumerator.sv =====
// PCI ECAM bus enumerator. Program ecam_base, first_bus and last_bus, then send a request
// with tuser 0 to start a scan; each configuration read request comes out with kind 0 and
// its dword is returned as a request with tuser 1. Per present function the block emits an
// identity record, six decoded BARs and a device-end record with the IRQ line, and ends with
// a finish record carrying the device count and status. Input requests are registered and
// decoded in a single pass into a three-entry result buffer: one request is taken per cycle
// while each produces one result and the output is not stalled; a request producing n
// results (at most three) holds the input while the buffer drains them, one per ready cycle.
`timescale 1ns / 1ps

module pci_config_space_enumerator (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [1:0] cfg_index,
	input logic [63:0] cfg_wr_data,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [31:0] s_axis_tdata, // read_data
	input logic s_axis_tuser, // operation
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// address, bus_number, device_number, function_number, identity, class_triple,
	// bar_index, value, status, zero pad
	output logic [207:0] m_axis_tdata,
	output logic [2:0] m_axis_tuser, // kind
	output logic m_axis_tlast
);

	logic [63:0] ecam_base_q;
	logic [7:0] first_bus_q, last_bus_q;

	logic valid_s1, op_s1;
	logic [31:0] data_s1;

	pce_pkg::scan_state_t st_q, st_next;
	pce_pkg::result_t res [3];
	pce_pkg::result_t head;
	logic [1:0] n;
	logic can_load, process;

	assign process = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecam_base_q <= 64'd0;
			first_bus_q <= 8'd0;
			last_bus_q <= 8'd0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pce_pkg::REG_ECAM_BASE: ecam_base_q <= cfg_wr_data;
				pce_pkg::REG_FIRST_BUS: first_bus_q <= cfg_wr_data[7:0];
				pce_pkg::REG_LAST_BUS: last_bus_q <= cfg_wr_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1 <= s_axis_tuser;
			data_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (process) begin
			st_q <= st_next;
		end
	end

	pce_step u_step (
		.st(st_q),
		.op(op_s1),
		.data(data_s1),
		.ecam_base(ecam_base_q),
		.first_bus(first_bus_q),
		.last_bus(last_bus_q),
		.st_next(st_next),
		.res(res),
		.n(n)
	);

	pce_rbuf u_rbuf (
		.clk(clk),
		.arst_n(arst_n),
		.load(process),
		.res(res),
		.n(n),
		.ready(m_axis_tready),
		.valid(m_axis_tvalid),
		.head(head),
		.can_load(can_load)
	);

	assign m_axis_tdata = {3'd0, head.status, head.value, head.bar_index, head.class_triple,
		head.identity, head.function_number, head.device_number, head.bus_number,
		head.address};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

endmodule

// ===== design/pce_checker.sv =====
`timescale 1ns / 1ps

module pce_checker (
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [207:0] m_axis_tdata,
	input logic [2:0] m_axis_tuser,
	input logic m_axis_tlast
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// a read request or a finish always closes the results of its request
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == pce_pkg::KIND_REQUEST ||
		m_axis_tuser == pce_pkg::KIND_FINISH) |-> m_axis_tlast)
		else $error("request or finish not marked last");

	// records are always followed by a request or a finish
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == pce_pkg::KIND_IDENTITY ||
		m_axis_tuser == pce_pkg::KIND_BAR || m_axis_tuser == pce_pkg::KIND_DEV_END)
		|-> !m_axis_tlast)
		else $error("record marked last");

	// status is only carried by a finish
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != pce_pkg::KIND_FINISH
		|-> m_axis_tdata[204:203] == 2'd0)
		else $error("status on a non-finish result");

	// a BAR record right after a BAR record carries the next index up
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser == pce_pkg::KIND_BAR ##1
		m_axis_tvalid && m_axis_tuser == pce_pkg::KIND_BAR
		|-> m_axis_tdata[138:136] == $past(m_axis_tdata[138:136]) + 3'd1)
		else $error("BAR index out of order");

endmodule

bind pci_config_space_enumerator pce_checker u_pce_checker (.*);

// ===== bench/pci_config_space_enumerator_test.sv =====
`timescale 1ns / 1ps

module pci_config_space_enumerator_test;
	import pce_pkg::*;

	localparam logic OP_READ_DATA = 1'b1;
	localparam logic [11:0] OFF_ID = 12'h000;
	localparam logic [11:0] OFF_CLASS = 12'h008;
	localparam logic [11:0] OFF_HDR = 12'h00c;
	localparam logic [11:0] OFF_BAR0 = 12'h010;
	localparam logic [11:0] OFF_IRQ = 12'h03c;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD = 300;
	localparam int QUIET_LIMIT = 3000;
	localparam int TARGET_ITEMS = 360;
	localparam int TARGET_SCANS = 3;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [63:0] cfg_wr_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata; // read_data
	logic s_axis_tuser; // operation
	logic m_axis_tvalid;
	logic m_axis_tready;
	// address, bus_number, device_number, function_number, identity, class_triple,
	// bar_index, value, status, zero pad
	logic [207:0] m_axis_tdata;
	logic [2:0] m_axis_tuser; // kind
	logic m_axis_tlast;

	bit calm = 0;
	bit long_hold_due = 0;
	int quiet_cycles = 0;

	pci_config_space_enumerator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// tracks the scan walk and holds the records the block still owes us
	class scan_tracker;
		logic [63:0] ecam_base;
		logic [7:0] first_bus;
		logic [7:0] last_bus;
		scan_state_t st;
		result_t due_records[$];
		result_t batch[$];
		int errors;

		function new();
			ecam_base = '0;
			first_bus = '0;
			last_bus = '0;
			st = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] v);
			case (idx)
				REG_ECAM_BASE: ecam_base = v;
				REG_FIRST_BUS: first_bus = v[7:0];
				REG_LAST_BUS: last_bus = v[7:0];
				default: ;
			endcase
		endfunction

		function result_t where_record(kind_t k);
			result_t r;
			r = '0;
			r.kind = k;
			r.bus_number = st.bus;
			r.device_number = st.dev;
			r.function_number = st.fn;
			return r;
		endfunction

		function void issue_read(logic [11:0] off);
			result_t r;
			r = where_record(KIND_REQUEST);
			r.address = ecam_base + (64'(st.bus) << 20) + (64'(st.dev) << 15)
				+ (64'(st.fn) << 12) + 64'(off & 12'hffc);
			batch.push_back(r);
		endfunction

		function void finish_scan(logic [1:0] status);
			result_t r;
			r = '0;
			r.kind = KIND_FINISH;
			r.value = 64'(st.count);
			r.status = status;
			st.busy = 1'b0;
			batch.push_back(r);
		endfunction

		function void scan_done();
			finish_scan(st.count != 0 ? ST_OK : ST_NONE_FOUND);
		endfunction

		function void next_device();
			logic [7:0] top_bus;
			top_bus = (last_bus < first_bus) ? first_bus : last_bus;
			if (st.count >= MAX_DEVICES) begin
				scan_done();
				return;
			end
			st.fn = '0;
			st.phase = PH_ID;
			if (st.dev < 5'd31) begin
				st.dev = st.dev + 5'd1;
				issue_read(OFF_ID);
			end else if (st.bus == 8'd255 || st.bus >= top_bus) begin
				scan_done();
			end else begin
				st.bus = st.bus + 8'd1;
				st.dev = '0;
				issue_read(OFF_ID);
			end
		endfunction

		function void next_function();
			if (st.count >= MAX_DEVICES) begin
				scan_done();
			end else if (st.fn < 3'd7) begin
				st.fn = st.fn + 3'd1;
				st.phase = PH_ID;
				issue_read(OFF_ID);
			end else begin
				next_device();
			end
		endfunction

		function void bar_record(logic [2:0] idx, logic [63:0] v);
			result_t r;
			r = where_record(KIND_BAR);
			r.bar_index = idx;
			r.value = v;
			batch.push_back(r);
		endfunction

		function void after_bar();
			if (st.bar_slot < 3'd6) begin
				st.phase = PH_BAR;
				issue_read(OFF_BAR0 + {7'b0, st.bar_slot, 2'b00});
			end else begin
				st.phase = PH_IRQ;
				issue_read(OFF_IRQ);
			end
		endfunction

		function void take_item(logic op, logic [31:0] d);
			result_t r;
			logic [2:0] upper;
			batch.delete();
			if (op == OP_START) begin
				if (ecam_base == '0) begin
					finish_scan(ST_NO_BASE);
				end else begin
					st.count = '0;
					st.bus = first_bus;
					st.dev = '0;
					st.fn = '0;
					st.bar_slot = '0;
					st.phase = PH_ID;
					st.busy = 1'b1;
					issue_read(OFF_ID);
				end
			end else if (st.busy) begin
				case (st.phase)
					PH_ID: begin
						if (d[15:0] == 16'hffff) begin
							if (st.fn == '0) next_device();
							else next_function();
						end else begin
							st.held_identity = d;
							st.phase = PH_CLASS;
							issue_read(OFF_CLASS);
						end
					end
					PH_CLASS: begin
						st.count = st.count + 7'd1;
						r = where_record(KIND_IDENTITY);
						r.identity = st.held_identity;
						r.class_triple = d[31:8];
						batch.push_back(r);
						st.bar_slot = '0;
						after_bar();
					end
					PH_BAR: begin
						if (d[2:0] == 3'b100 && d != '1 && st.bar_slot < 3'd5) begin
							// 64-bit memory BAR: fetch the upper half first
							st.held_bar_low = d;
							st.phase = PH_BARHI;
							upper = st.bar_slot + 3'd1;
							issue_read(OFF_BAR0 + {7'b0, upper, 2'b00});
						end else begin
							if (d == '0 || d == '1) bar_record(st.bar_slot, '0);
							else if (d[0]) bar_record(st.bar_slot, {32'b0, d[31:2], 2'b00});
							else bar_record(st.bar_slot, {32'b0, d[31:4], 4'b0000});
							st.bar_slot = st.bar_slot + 3'd1;
							after_bar();
						end
					end
					PH_BARHI: begin
						bar_record(st.bar_slot, {d, st.held_bar_low[31:4], 4'b0000});
						bar_record(st.bar_slot + 3'd1, '0);
						st.bar_slot = st.bar_slot + 3'd2;
						after_bar();
					end
					PH_IRQ: begin
						r = where_record(KIND_DEV_END);
						r.value = {56'b0, d[7:0]};
						batch.push_back(r);
						if (st.fn == '0) begin
							st.phase = PH_HDR;
							issue_read(OFF_HDR);
						end else begin
							next_function();
						end
					end
					default: begin
						// header type: multifunction bit
						if (!d[23]) next_device();
						else next_function();
					end
				endcase
			end
			if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i]) due_records.push_back(batch[i]);
		endfunction

		function string describe(result_t r);
			return $sformatf({"kind=%0d addr=%h bus=%0d dev=%0d fn=%0d id=%h class=%h ",
				"bar=%0d value=%h status=%0d last=%0d"}, r.kind, r.address, r.bus_number,
				r.device_number, r.function_number, r.identity, r.class_triple,
				r.bar_index, r.value, r.status, r.last);
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= 10) $display("%s", msg);
		endfunction

		function void check_record(result_t got);
			result_t want;
			string bad;
			if (due_records.size() == 0) begin
				note_error({"result with nothing expected: ", describe(got)});
				return;
			end
			want = due_records.pop_front();
			bad = "";
			if (got.kind !== want.kind) bad = {bad, " kind"};
			if (got.address !== want.address) bad = {bad, " address"};
			if (got.bus_number !== want.bus_number) bad = {bad, " bus"};
			if (got.device_number !== want.device_number) bad = {bad, " device"};
			if (got.function_number !== want.function_number) bad = {bad, " function"};
			if (got.identity !== want.identity) bad = {bad, " identity"};
			if (got.class_triple !== want.class_triple) bad = {bad, " class"};
			if (got.bar_index !== want.bar_index) bad = {bad, " bar_index"};
			if (got.value !== want.value) bad = {bad, " value"};
			if (got.status !== want.status) bad = {bad, " status"};
			if (got.last !== want.last) bad = {bad, " last"};
			if (bad != "")
				note_error($sformatf("mismatch in%s\n  expected %s\n  actual   %s", bad,
					describe(want), describe(got)));
		endfunction
	endclass

	scan_tracker sb = new();
	int driven_items = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic result_t unpack_record(logic [207:0] data, logic [2:0] k, logic l);
		result_t r;
		r.kind = kind_t'(k);
		r.address = data[63:0];
		r.bus_number = data[71:64];
		r.device_number = data[76:72];
		r.function_number = data[79:77];
		r.identity = data[111:80];
		r.class_triple = data[135:112];
		r.bar_index = data[138:136];
		r.value = data[202:139];
		r.status = data[204:203];
		r.last = l;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_record(unpack_record(m_axis_tdata, m_axis_tuser, m_axis_tlast));
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("pci_config_space_enumerator verification failed");
				$finish;
			end
		end
	end

	// result side backpressure
	initial begin
		int stretch;
		int gap_pct;
		m_axis_tready = 1'b0;
		stretch = 0;
		gap_pct = 0;
		forever begin
			@(negedge clk);
			if (stretch % 64 == 0) gap_pct = $urandom_range(0, 2) * 25;
			stretch++;
			if (long_hold_due) begin
				long_hold_due = 0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!calm && arst_n && $urandom_range(0, 99) < gap_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// entered and left at a falling edge
	task automatic offer(logic op, logic [31:0] d);
		bit ignored;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		ignored = (op != OP_START) && !sb.st.busy;
		sb.take_item(op, d);
		if (!ignored) driven_items++;
		@(negedge clk);
	endtask

	task automatic pause_sender(int n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// registers only change once the block has gone quiet
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.due_records.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(logic [1:0] idx, logic [63:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= v;
		sb.write_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic load_registers(logic [63:0] base, logic [7:0] first, logic [7:0] last);
		put_reg(REG_ECAM_BASE, base);
		put_reg(REG_FIRST_BUS, {56'b0, first});
		put_reg(REG_LAST_BUS, {56'b0, last});
		cfg_wr_en <= 1'b0;
	endtask

	// dword shaped for the read the walk is waiting on
	function automatic logic [31:0] config_dword(int present_pct, int multi_pct);
		logic [31:0] d;
		d = $urandom;
		if ($urandom_range(0, 49) == 0) return d;
		case (sb.st.phase)
			PH_ID: begin
				if ($urandom_range(0, 99) < present_pct) begin
					if (d[15:0] == 16'hffff) d[15:0] = 16'h0000;
				end else begin
					d[15:0] = 16'hffff;
				end
			end
			PH_BAR: begin
				case ($urandom_range(0, 5))
					0: d = '0;
					1: d = '1;
					2: d[0] = 1'b1;
					3: d[2:0] = 3'b100;
					4: d[2:0] = {d[3] & 1'b0, 2'b00};
					default: d[0] = 1'b0;
				endcase
			end
			PH_HDR: d[23] = ($urandom_range(0, 99) < multi_pct);
			default: ;
		endcase
		return d;
	endfunction

	initial begin
		int scans;
		int present_pct;
		int multi_pct;
		int tx_gap_pct;
		logic [63:0] base;
		logic [7:0] fb;
		logic [7:0] lb;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		offer(OP_READ_DATA, 32'h0000_0000); // nothing running: dropped
		offer(OP_START, 32'hffff_ffff); // no base programmed
		settle();
		load_registers(64'hffff_ffff_ffff_ffff, 8'd255, 8'd0);
		offer(OP_START, 32'h0000_0000);
		offer(OP_READ_DATA, 32'h0000_0000); // vendor 0, device 0
		offer(OP_READ_DATA, 32'hffff_ffff);
		offer(OP_READ_DATA, 32'hffff_fff4); // 64-bit memory
		offer(OP_READ_DATA, 32'hffff_ffff);
		offer(OP_READ_DATA, 32'hffff_ffff); // unimplemented
		offer(OP_READ_DATA, 32'h0000_0000);
		offer(OP_READ_DATA, 32'hffff_fffd); // I/O
		offer(OP_READ_DATA, 32'h8000_000c); // 64-bit type in last slot decodes as 32-bit
		offer(OP_READ_DATA, 32'h0000_00ff);
		offer(OP_READ_DATA, 32'h0080_0000); // multifunction
		offer(OP_READ_DATA, 32'h0000_ffff); // function 1 absent
		offer(OP_READ_DATA, 32'hfffe_fffe);
		offer(OP_READ_DATA, 32'h1234_5678);
		offer(OP_READ_DATA, 32'h0000_0001);
		offer(OP_START, 32'h0000_0000); // restart mid scan
		offer(OP_READ_DATA, 32'hffff_ffff); // slot empty

		scans = 0;
		present_pct = 20;
		multi_pct = 20;
		tx_gap_pct = 20;
		while (!(scans >= TARGET_SCANS && driven_items >= TARGET_ITEMS && !sb.st.busy)) begin
			if (!sb.st.busy) begin
				settle();
				if (scans == 0) begin
					// single-bus scan under a long result stall
					base = {$urandom, $urandom} | 64'h1;
					fb = $urandom_range(0, 255);
					load_registers(base, fb, fb);
					present_pct = 35;
					multi_pct = 0;
					long_hold_due = 1;
				end else begin
					case ($urandom_range(0, 7))
						0: base = '0;
						1: base = '1;
						default: base = {$urandom, $urandom};
					endcase
					case ($urandom_range(0, 3))
						0: fb = 8'd0;
						1: fb = 8'd255;
						default: fb = $urandom_range(0, 255);
					endcase
					case ($urandom_range(0, 2))
						0: lb = fb;
						1: lb = $urandom_range(0, fb);
						default: lb = (fb == 8'd255) ? 8'd255 : fb + 8'd1;
					endcase
					load_registers(base, fb, lb);
					present_pct = $urandom_range(0, 2) * 12;
					multi_pct = $urandom_range(0, 1) * 30;
				end
				scans++;
				calm = (scans >= TARGET_SCANS - 1);
				tx_gap_pct = $urandom_range(0, 2) * 15;
				if ($urandom_range(0, 3) == 0) offer(OP_READ_DATA, $urandom);
				offer(OP_START, $urandom);
			end else begin
				if (!calm && $urandom_range(0, 99) < tx_gap_pct)
					pause_sender($urandom_range(1, 5));
				if ($urandom_range(0, 299) == 0)
					offer(OP_START, $urandom);
				else
					offer(OP_READ_DATA, config_dword(present_pct, multi_pct));
			end
		end

		s_axis_tvalid <= 1'b0;
		while (sb.due_records.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.due_records.size() == 0)
			$display("pci_config_space_enumerator verification clean");
		else
			$display("pci_config_space_enumerator verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/pce_pkg.sv
design/pce_step.sv
design/pce_rbuf.sv
design/pci_config_space_enumerator.sv
design/pce_checker.sv
bench/pci_config_space_enumerator_test.sv
